FILE: rtl/core/radix_digit_converter_defines.svh
// Assertion macros for the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdc assertion failed");
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdc assertion failed");
`else
`define RDC_ASSERT_SAME(label, clk, rst, ante, cons)
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic [RADIX_W-1:0]   RADIX_RESET = 5'd16;
   localparam logic [RADIX_W-1:0]   RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0]   RADIX_MAX   = 5'd16;
   localparam logic [CSR_IDX_W-1:0] REG_RADIX   = 1'b0;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/rdc_divider.sv
`timescale 1ns / 1ps

// restoring divide by a small radix, one quotient bit per cycle
module rdc_divider #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VALUE_WIDTH-1:0]          dividend,
   input  logic [rdc_pkg::RADIX_W-1:0]     divisor,
   output logic [VALUE_WIDTH-1:0]          quotient,
   output rdc_pkg::div_status_type         status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0]        quot_ff, quot_in;
   logic [rdc_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rdc_pkg::RADIX_W-1:0]   trial;
   logic [rdc_pkg::RADIX_W-1:0]   diff;
   logic                          ge;

   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign ge    = (trial >= divisor);
   assign diff  = trial - divisor;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], ge};
         rem_in  = ge ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign quotient         = quot_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: rtl/core/radix_digit_converter.sv
`timescale 1ns / 1ps
`include "radix_digit_converter_defines.svh"

// Converts req_value to digits in the radix held in the radix register (values
// below 2 act as 2, above 16 as 16). A word is taken when start is high and busy
// is low. One shared divider produces the digits one by one, least
// significant first, onto a digit stack; the stack is then popped at one digit
// per cycle, most significant first, each on rsp_digit for one cycle with
// rsp_strobe high and rsp_last_digit high on the final digit. Zero gives the
// single digit 0. The receiver cannot stall, so digits must be taken as they
// appear. At most MAX_DIGITS digits are kept, the least significant ones.
module radix_digit_converter #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [VALUE_WIDTH-1:0]            req_value,
   output logic                              rsp_strobe,
   output logic [rdc_pkg::DIGIT_W-1:0]       rsp_digit,
   output logic                              rsp_last_digit,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rdc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rdc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W  = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_POP
   } state_type;

   state_type                         state_ff, state_in;
   logic [COUNT_W-1:0]                count_ff, count_in;
   logic                              strobe_ff, strobe_in;
   logic                              last_ff, last_in;
   logic [rdc_pkg::RADIX_W-1:0]       radix_ff, radix_in;
   logic [rdc_pkg::DIGIT_W-1:0]       digit_ff;
   logic [rdc_pkg::DIGIT_W-1:0]       stack_mem [MAX_DIGITS];

   logic                              accept;
   logic                              value_zero;
   logic                              csr_wr;
   logic [rdc_pkg::CSR_IDX_W-1:0]     csr_idx;
   logic [rdc_pkg::RADIX_W-1:0]       radix_eff;
   logic [COUNT_W-1:0]                count_inc;
   logic [COUNT_W-1:0]                count_dec;
   logic                              div_start;
   logic [VALUE_WIDTH-1:0]            div_dividend;
   logic [VALUE_WIDTH-1:0]            div_quotient;
   rdc_pkg::div_status_type           div_status;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic [rdc_pkg::DIGIT_W-1:0]       mem_wdata;
   logic                              mem_re;
   logic                              div_more;
   logic [rdc_pkg::RADIX_W-1:0]       digit_ext;

   // config port
   assign pready  = 1'b1;
   assign csr_idx = paddr[rdc_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready && (csr_idx == rdc_pkg::REG_RADIX);
   assign prdata  = (csr_idx == rdc_pkg::REG_RADIX) ?
                    {{(rdc_pkg::CSR_DATA_W - rdc_pkg::RADIX_W){1'b0}}, radix_ff} : '0;
   assign radix_in  = csr_wr ? pwdata[rdc_pkg::RADIX_W-1:0] : radix_ff;
   assign radix_eff = rdc_pkg::eff_radix(radix_ff);

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign value_zero = (req_value == '0);
   assign count_inc  = count_ff + COUNT_W'(1);
   assign count_dec  = count_ff - COUNT_W'(1);
   assign div_more   = (div_quotient != '0) && (count_inc != COUNT_W'(MAX_DIGITS));

   assign div_dividend = (state_ff == ST_IDLE) ? req_value : div_quotient;
   assign div_start    = (accept && !value_zero) ||
                         ((state_ff == ST_DIV) && div_status.done && div_more);

   rdc_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_eff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // digit stack
   assign mem_we    = (accept && value_zero) || ((state_ff == ST_DIV) && div_status.done);
   assign mem_waddr = (state_ff == ST_IDLE) ? '0 : count_ff[ADDR_W-1:0];
   assign mem_wdata = (state_ff == ST_IDLE) ? '0 : div_status.remainder;
   assign mem_re    = (state_ff == ST_POP);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         digit_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      last_in   = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (value_zero) begin
                  count_in = COUNT_W'(1);
                  state_in = ST_POP;
               end else begin
                  count_in = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = count_inc;
               if (!div_more) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            count_in  = count_dec;
            strobe_in = 1'b1;
            last_in   = (count_dec == '0);
            if (count_dec == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         radix_ff  <= rdc_pkg::RADIX_RESET;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
         radix_ff  <= radix_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit      = digit_ff;
   assign rsp_last_digit = last_ff;

   assign digit_ext = {1'b0, rsp_digit};

   `RDC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `RDC_ASSERT_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_last_digit, !rsp_strobe)
   `RDC_ASSERT_SAME(a_digit_range, clock, reset, rsp_strobe, digit_ext < radix_eff)
   `RDC_ASSERT_SAME(a_stack_room, clock, reset, state_ff == ST_DIV, count_ff < COUNT_W'(MAX_DIGITS))

endmodule

FILE: verif/radix_digit_checker.sv
`timescale 1ns / 1ps

module radix_digit_checker #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [VALUE_WIDTH-1:0]           req_value,
   input  logic                             rsp_strobe,
   input  logic [rdc_pkg::DIGIT_W-1:0]      rsp_digit,
   input  logic                             rsp_last_digit,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rdc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic                             pready,
   output int                               mismatches,
   output int                               digits_pending
);

   localparam int DIGIT_W    = rdc_pkg::DIGIT_W;
   localparam int RADIX_W    = rdc_pkg::RADIX_W;
   localparam int CSR_ADDR_W = rdc_pkg::CSR_ADDR_W;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } digit_word_type;

   digit_word_type         expected_digits[$];
   logic [DIGIT_W-1:0]     digit_stack[$];
   logic [RADIX_W-1:0]     radix_shadow;
   logic [VALUE_WIDTH-1:0] quotient;
   logic [VALUE_WIDTH-1:0] base;
   digit_word_type         w;
   int                     fail_total;

   always @(posedge clock) begin
      if (reset) begin
         expected_digits.delete();
         radix_shadow = rdc_pkg::RADIX_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit word, actual digit %0d last %0b",
                        $time, rsp_digit, rsp_last_digit);
               fail_total++;
            end else begin
               w = expected_digits.pop_front();
               if (rsp_digit !== w.digit) begin
                  $display("%0t: digit mismatch, expected %0d actual %0d",
                           $time, w.digit, rsp_digit);
                  fail_total++;
               end
               if (rsp_last_digit !== w.last) begin
                  $display("%0t: last_digit mismatch, expected %0b actual %0b",
                           $time, w.last, rsp_last_digit);
                  fail_total++;
               end
            end
         end

         if (start && !busy) begin
            // out-of-range radix settings saturate to the nearest legal base
            if (radix_shadow < rdc_pkg::RADIX_MIN) begin
               base = VALUE_WIDTH'(rdc_pkg::RADIX_MIN);
            end else if (radix_shadow > rdc_pkg::RADIX_MAX) begin
               base = VALUE_WIDTH'(rdc_pkg::RADIX_MAX);
            end else begin
               base = VALUE_WIDTH'(radix_shadow);
            end
            quotient = req_value;
            digit_stack.delete();
            if (quotient == '0) begin
               digit_stack.push_back('0);
            end
            while (quotient != '0 && digit_stack.size() < MAX_DIGITS) begin
               digit_stack.push_back(DIGIT_W'(quotient % base));
               quotient = quotient / base;
            end
            while (digit_stack.size() > 0) begin
               w.digit = digit_stack.pop_back();
               w.last  = (digit_stack.size() == 0);
               expected_digits.push_back(w);
            end
         end

         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == rdc_pkg::REG_RADIX) begin
            radix_shadow = pwdata[RADIX_W-1:0];
         end
      end
      mismatches <= fail_total;
      digits_pending <= expected_digits.size();
   end

endmodule

FILE: verif/radix_digit_converter_tb.sv
`timescale 1ns / 1ps

module radix_digit_converter_tb;

   localparam int VALUE_WIDTH  = 32;
   localparam int MAX_DIGITS   = 32;
   localparam int WORD_GAP_MAX = 11;
   localparam int PHASE_WORDS  = 60;
   localparam int PHASES       = 8;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RADIX_W      = rdc_pkg::RADIX_W;
   localparam int DIGIT_W      = rdc_pkg::DIGIT_W;
   localparam int CSR_ADDR_W   = rdc_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = rdc_pkg::CSR_DATA_W;
   localparam logic [CSR_ADDR_W-1:0] RADIX_ADDR = CSR_ADDR_W'({rdc_pkg::REG_RADIX, 2'b00});

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_strobe;
   logic [DIGIT_W-1:0]     rsp_digit;
   logic                   rsp_last_digit;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   int                     mismatches;
   int                     digits_pending;
   logic [VALUE_WIDTH-1:0] word_list[$];
   bit                     no_idle;
   int unsigned            cur_base;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   radix_digit_converter #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_digit     (rsp_digit),
      .rsp_last_digit(rsp_last_digit),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   radix_digit_checker #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_digit     (rsp_digit),
      .rsp_last_digit(rsp_last_digit),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .mismatches    (mismatches),
      .digits_pending(digits_pending)
   );

   function automatic int pick_gap();
      return no_idle ? 0 : $urandom_range(0, WORD_GAP_MAX);
   endfunction

   // block must be idle: every digit back and busy low
   task automatic set_radix(input logic [RADIX_W-1:0] r, input bit junk);
      do @(posedge clock); while (digits_pending != 0 || busy);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RADIX_ADDR;
      pwdata  <= {junk ? (CSR_DATA_W-RADIX_W)'($urandom()) : (CSR_DATA_W-RADIX_W)'(0), r};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_base = (r < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
                 (r > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX : r;
   endtask

   // start stays high across back-to-back words
   task automatic send_batch();
      int gap;
      gap = pick_gap();
      for (int i = 0; i < word_list.size(); i++) begin
         repeat (gap) @(posedge clock);
         gap = pick_gap();
         start     <= 1'b1;
         req_value <= word_list[i];
         do @(posedge clock); while (busy);
         if (!(i < word_list.size() - 1 && gap == 0)) begin
            start <= 1'b0;
         end
      end
      word_list.delete();
   endtask

   initial begin
      logic [RADIX_W-1:0]     radix_plan[$];
      logic [VALUE_WIDTH-1:0] v;
      longint unsigned        p;
      int                     k;
      int                     n;

      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      no_idle   = 1'b0;
      cur_base  = rdc_pkg::RADIX_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset radix
      word_list = '{32'd0, 32'd1, 32'd15, 32'd16, 32'd255, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h1234_5678};
      send_batch();
      set_radix(5'd2, 1'b0);
      word_list = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 32'h5555_5555};
      send_batch();
      set_radix(5'd0, 1'b1);
      word_list = '{32'd5};
      send_batch();
      set_radix(5'd1, 1'b0);
      word_list = '{32'd6};
      send_batch();
      set_radix(5'd17, 1'b1);
      word_list = '{32'd255};
      send_batch();
      set_radix(5'd31, 1'b0);
      word_list = '{32'hFFFF_FFFF};
      send_batch();
      set_radix(5'd3, 1'b0);
      word_list = '{32'hFFFF_FFFF, 32'd3486784401, 32'd3486784400};
      send_batch();
      set_radix(5'd10, 1'b1);
      word_list = '{32'd4294967295, 32'd1000000000, 32'd999999999};
      send_batch();
      set_radix(5'd7, 1'b0);
      word_list = '{32'd6, 32'd7};
      send_batch();

      radix_plan = '{5'd2, 5'd16};
      while (radix_plan.size() < PHASES) begin
         radix_plan.push_back(RADIX_W'($urandom_range(0, 31)));
      end
      foreach (radix_plan[ph]) begin
         set_radix(radix_plan[ph], bit'($urandom_range(0, 1)));
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            case ($urandom_range(0, 9))
               0: v = '0;
               1, 2, 3: v = $urandom();
               4, 5: v = $urandom() >> $urandom_range(0, 31);
               6: begin
                  // around a power of the base, where the digit count steps
                  p = 1;
                  k = $urandom_range(1, 32);
                  while (k > 0 && p * cur_base <= 64'hFFFF_FFFF) begin
                     p = p * cur_base;
                     k--;
                  end
                  v = VALUE_WIDTH'(p - $urandom_range(0, 1));
               end
               7: v = '1;
               8: v = $urandom_range(0, cur_base * cur_base);
               default: v = VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
            endcase
            word_list.push_back(v);
         end
         send_batch();
      end

      n = 0;
      do begin
         @(posedge clock);
         n++;
      end while ((digits_pending != 0 || busy) && n < DRAIN_LIMIT);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && digits_pending == 0) begin
         $display("** radix_digit_converter: PASSED **");
      end else begin
         if (digits_pending != 0) begin
            $display("%0t: %0d expected digits never arrived", $time, digits_pending);
         end
         $display("** radix_digit_converter: FAILED **");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("%0t: timeout", $time);
      $display("** radix_digit_converter: FAILED **");
      $finish;
   end

endmodule

FILE: radix_digit_converter.f
+incdir+rtl/core
rtl/core/rdc_pkg.sv
rtl/core/rdc_divider.sv
rtl/core/radix_digit_converter.sv
verif/radix_digit_checker.sv
verif/radix_digit_converter_tb.sv
